// ----- sv/hpg_pkg.sv -----
`default_nettype none

package hpg_pkg;

   localparam int IDX_W           = 24;
   localparam int DIR_W           = 4;
   localparam int CSR_DATA_W      = 9;
   localparam int CSR_INDEX_W     = 2;
   localparam int MAX_DIM_DEFAULT = 256;
   localparam int SIZE_RESET      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_X = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Y = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Z = CSR_INDEX_W'(2);

   localparam logic [DIR_W-1:0] DIR_E     = DIR_W'(0);
   localparam logic [DIR_W-1:0] DIR_SE    = DIR_W'(1);
   localparam logic [DIR_W-1:0] DIR_SW    = DIR_W'(2);
   localparam logic [DIR_W-1:0] DIR_W_    = DIR_W'(3);
   localparam logic [DIR_W-1:0] DIR_NW    = DIR_W'(4);
   localparam logic [DIR_W-1:0] DIR_NE    = DIR_W'(5);
   localparam logic [DIR_W-1:0] DIR_UP    = DIR_W'(6);
   localparam logic [DIR_W-1:0] DIR_DOWN  = DIR_W'(7);
   localparam logic [DIR_W-1:0] DIR_COUNT = DIR_W'(8);

   typedef struct packed {
      logic [IDX_W-1:0] cell_index;
      logic [DIR_W-1:0] direction;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] neighbor_index;
      logic             neighbor_valid;
   } rsp_type;

   function automatic logic signed [1:0] hex_dq(input logic [DIR_W-1:0] dir);
      case (dir)
         DIR_E:   return 2'sb01;
         DIR_SE:  return 2'sb00;
         DIR_SW:  return 2'sb11;
         DIR_W_:  return 2'sb11;
         DIR_NW:  return 2'sb00;
         DIR_NE:  return 2'sb01;
         default: return 2'sb00;
      endcase
   endfunction

   function automatic logic signed [1:0] hex_dr(input logic [DIR_W-1:0] dir);
      case (dir)
         DIR_E:   return 2'sb00;
         DIR_SE:  return 2'sb01;
         DIR_SW:  return 2'sb01;
         DIR_W_:  return 2'sb00;
         DIR_NW:  return 2'sb11;
         DIR_NE:  return 2'sb11;
         default: return 2'sb00;
      endcase
   endfunction

endpackage

`default_nettype wire

// ----- sv/hpg_div_pipe.sv -----
`default_nettype none

module hpg_div_pipe #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 18,
   parameter int QUO_W      = 8,
   parameter int SIDE_W     = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [DIVIDEND_W-1:0] in_dividend,
   input  logic [DIVISOR_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [QUO_W-1:0]      out_quotient,
   output logic [DIVIDEND_W-1:0] out_remainder,
   output logic [DIVISOR_W-1:0]  out_divisor,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int TRIAL_W = (DIVIDEND_W > DIVISOR_W + QUO_W) ? DIVIDEND_W : DIVISOR_W + QUO_W;

   logic                  valid_ff [QUO_W];
   logic [DIVIDEND_W-1:0] rem_ff   [QUO_W];
   logic [QUO_W-1:0]      quo_ff   [QUO_W];
   logic [DIVISOR_W-1:0]  div_ff   [QUO_W];
   logic [SIDE_W-1:0]     side_ff  [QUO_W];

   // One quotient bit per stage, most significant bit first.
   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;

      logic                  prev_valid;
      logic [DIVIDEND_W-1:0] prev_rem;
      logic [QUO_W-1:0]      prev_quo;
      logic [DIVISOR_W-1:0]  prev_div;
      logic [SIDE_W-1:0]     prev_side;
      logic [TRIAL_W-1:0]    trial;
      logic                  take;
      logic [DIVIDEND_W-1:0] rem_in;
      logic [QUO_W-1:0]      quo_in;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_dividend;
         assign prev_quo   = '0;
         assign prev_div   = in_divisor;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_quo   = quo_ff[s-1];
         assign prev_div   = div_ff[s-1];
         assign prev_side  = side_ff[s-1];
      end

      assign trial = TRIAL_W'(prev_div) << BIT;
      assign take  = TRIAL_W'(prev_rem) >= trial;

      always_comb begin
         rem_in      = take ? DIVIDEND_W'(TRIAL_W'(prev_rem) - trial) : prev_rem;
         quo_in      = prev_quo;
         quo_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         quo_ff[s]  <= quo_in;
         div_ff[s]  <= prev_div;
         side_ff[s] <= prev_side;
      end
   end

   assign out_valid     = valid_ff[QUO_W-1];
   assign out_quotient  = quo_ff[QUO_W-1];
   assign out_remainder = rem_ff[QUO_W-1];
   assign out_divisor   = div_ff[QUO_W-1];
   assign out_side      = side_ff[QUO_W-1];

endmodule

`default_nettype wire

// ----- sv/hex_prism_grid_neighbor_index_unit.sv -----
`default_nettype none

// Neighbor lookup in a layered odd-r hexagonal grid.
// A query item (cell index and direction) is accepted at a rising edge where
// start is high and busy is low. Busy is high only during reset, so the unit
// takes one item in every cycle with no gaps.
// Each result item appears on rsp_payload for exactly one cycle with
// rsp_strobe high. The pipeline holds the two restoring dividers, one
// quotient bit per stage, that split the index into layer, row and column,
// plus the multiply stages that rebuild the linear index.
// Results leave in order; the receiver cannot hold them off.
// The grid sizes are written through the csr_ port (0 size_x, 1 size_y,
// 2 size_z); a value of zero acts as one and a value above MAX_DIM acts as
// MAX_DIM. Sizes must only be written while no item is in flight.
// Reset is synchronous: it empties the pipeline and sets all sizes to 16.
module hex_prism_grid_neighbor_index_unit #(
   parameter int MAX_DIM = hpg_pkg::MAX_DIM_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  hpg_pkg::req_type                   req_payload,
   output logic                               rsp_strobe,
   output hpg_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_we,
   input  logic [hpg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hpg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import hpg_pkg::*;

   localparam int CW    = $clog2(MAX_DIM + 1);
   localparam int QW    = $clog2(MAX_DIM);
   localparam int AW    = 2 * CW;
   localparam int TW    = 3 * CW;
   localparam int CMP_W = (TW > IDX_W) ? TW : IDX_W;
   localparam int NW    = CW + 2;
   localparam int PY_W  = QW + CW;
   localparam int PZ_W  = QW + AW;
   localparam int FIN_W = TW + 1;
   localparam int LAT   = 2 * QW + 7;

   typedef struct packed {
      logic             ok;
      logic [DIR_W-1:0] dir;
   } zside_type;

   typedef struct packed {
      logic             ok;
      logic [DIR_W-1:0] dir;
      logic [QW-1:0]    z;
      logic [AW-1:0]    area;
   } yside_type;

   function automatic logic [CW-1:0] clamp_size(input logic [CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return CW'(1);
      end
      if (int'(v) > MAX_DIM) begin
         return CW'(MAX_DIM);
      end
      return CW'(v);
   endfunction

   logic [CW-1:0] size_x_ff;
   logic [CW-1:0] size_y_ff;
   logic [CW-1:0] size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= clamp_size(CSR_DATA_W'(SIZE_RESET));
         size_y_ff <= clamp_size(CSR_DATA_W'(SIZE_RESET));
         size_z_ff <= clamp_size(CSR_DATA_W'(SIZE_RESET));
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= clamp_size(csr_wdata);
            CSR_SIZE_Y: size_y_ff <= clamp_size(csr_wdata);
            CSR_SIZE_Z: size_z_ff <= clamp_size(csr_wdata);
            default: ;
         endcase
      end
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // Stage 1: capture the item and form the layer area.
   logic             vld1_ff;
   logic [IDX_W-1:0] idx1_ff;
   logic [DIR_W-1:0] dir1_ff;
   logic [AW-1:0]    area1_ff;
   // Stage 2: total cell count.
   logic             vld2_ff;
   logic [IDX_W-1:0] idx2_ff;
   logic [DIR_W-1:0] dir2_ff;
   logic [AW-1:0]    area2_ff;
   logic [TW-1:0]    total2_ff;
   // Stage 3: range check.
   logic             vld3_ff;
   logic [IDX_W-1:0] idx3_ff;
   logic [AW-1:0]    area3_ff;
   zside_type        zside3_ff;
   zside_type        zside3_in;

   always_comb begin
      zside3_in.ok  = (CMP_W'(idx2_ff) < CMP_W'(total2_ff)) && (dir2_ff < DIR_COUNT);
      zside3_in.dir = dir2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= accept;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff   <= req_payload.cell_index;
      dir1_ff   <= req_payload.direction;
      area1_ff  <= AW'(size_x_ff) * AW'(size_y_ff);
      idx2_ff   <= idx1_ff;
      dir2_ff   <= dir1_ff;
      area2_ff  <= area1_ff;
      total2_ff <= TW'(area1_ff) * TW'(size_z_ff);
      idx3_ff   <= idx2_ff;
      area3_ff  <= area2_ff;
      zside3_ff <= zside3_in;
   end

   // Layer and in-layer offset.
   logic             zdiv_valid;
   logic [QW-1:0]    zdiv_quo;
   logic [IDX_W-1:0] zdiv_rem;
   logic [AW-1:0]    zdiv_area;
   zside_type        zdiv_side;

   hpg_div_pipe #(
      .DIVIDEND_W (IDX_W),
      .DIVISOR_W  (AW),
      .QUO_W      (QW),
      .SIDE_W     ($bits(zside_type))
   ) u_zdiv (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (vld3_ff),
      .in_dividend   (idx3_ff),
      .in_divisor    (area3_ff),
      .in_side       (zside3_ff),
      .out_valid     (zdiv_valid),
      .out_quotient  (zdiv_quo),
      .out_remainder (zdiv_rem),
      .out_divisor   (zdiv_area),
      .out_side      (zdiv_side)
   );

   yside_type ydiv_side_in;

   always_comb begin
      ydiv_side_in.ok   = zdiv_side.ok;
      ydiv_side_in.dir  = zdiv_side.dir;
      ydiv_side_in.z    = zdiv_quo;
      ydiv_side_in.area = zdiv_area;
   end

   // Row and column.
   logic          ydiv_valid;
   logic [QW-1:0] ydiv_quo;
   logic [AW-1:0] ydiv_rem;
   logic [CW-1:0] ydiv_sx;
   yside_type     ydiv_side;

   hpg_div_pipe #(
      .DIVIDEND_W (AW),
      .DIVISOR_W  (CW),
      .QUO_W      (QW),
      .SIDE_W     ($bits(yside_type))
   ) u_ydiv (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (zdiv_valid),
      .in_dividend   (AW'(zdiv_rem)),
      .in_divisor    (size_x_ff),
      .in_side       (ydiv_side_in),
      .out_valid     (ydiv_valid),
      .out_quotient  (ydiv_quo),
      .out_remainder (ydiv_rem),
      .out_divisor   (ydiv_sx),
      .out_side      (ydiv_side)
   );

   // Neighbor coordinates in the odd-r layout.
   logic signed [NW-1:0] xs;
   logic signed [NW-1:0] ys;
   logic signed [NW-1:0] zs;
   logic signed [NW-1:0] nxs;
   logic signed [NW-1:0] nys;
   logic signed [NW-1:0] nzs;
   logic                 nok_in;

   always_comb begin
      xs  = $signed(NW'(ydiv_rem[QW-1:0]));
      ys  = $signed(NW'(ydiv_quo));
      zs  = $signed(NW'(ydiv_side.z));
      nxs = xs;
      nys = ys;
      nzs = zs;
      case (ydiv_side.dir)
         DIR_UP: begin
            nzs = zs + NW'(1);
         end
         DIR_DOWN: begin
            nzs = zs - NW'(1);
         end
         default: begin
            nys = ys + NW'(hex_dr(ydiv_side.dir));
            nxs = xs - (ys >>> 1) + NW'(hex_dq(ydiv_side.dir)) + (nys >>> 1);
         end
      endcase
      nok_in = ydiv_side.ok
               && (nxs >= 0) && (nxs < $signed(NW'(ydiv_sx)))
               && (nys >= 0) && (nys < $signed(NW'(size_y_ff)))
               && (nzs >= 0) && (nzs < $signed(NW'(size_z_ff)));
   end

   logic          vld4_ff;
   logic          ok4_ff;
   logic [QW-1:0] nx4_ff;
   logic [QW-1:0] ny4_ff;
   logic [QW-1:0] nz4_ff;
   logic [AW-1:0] area4_ff;

   logic            vld5_ff;
   logic            ok5_ff;
   logic [QW-1:0]   nx5_ff;
   logic [QW-1:0]   nz5_ff;
   logic [AW-1:0]   area5_ff;
   logic [PY_W-1:0] py5_ff;

   logic             vld6_ff;
   logic             ok6_ff;
   logic [FIN_W-1:0] part6_ff;
   logic [PZ_W-1:0]  pz6_ff;

   logic    rsp_strobe_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff       <= 1'b0;
         vld5_ff       <= 1'b0;
         vld6_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld4_ff       <= ydiv_valid;
         vld5_ff       <= vld4_ff;
         vld6_ff       <= vld5_ff;
         rsp_strobe_ff <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      ok4_ff   <= nok_in;
      nx4_ff   <= nxs[QW-1:0];
      ny4_ff   <= nys[QW-1:0];
      nz4_ff   <= nzs[QW-1:0];
      area4_ff <= ydiv_side.area;

      ok5_ff   <= ok4_ff;
      nx5_ff   <= nx4_ff;
      nz5_ff   <= nz4_ff;
      area5_ff <= area4_ff;
      py5_ff   <= PY_W'(ny4_ff) * PY_W'(size_x_ff);

      ok6_ff   <= ok5_ff;
      part6_ff <= FIN_W'(nx5_ff) + FIN_W'(py5_ff);
      pz6_ff   <= PZ_W'(nz5_ff) * PZ_W'(area5_ff);

      rsp_ff.neighbor_valid <= ok6_ff;
      rsp_ff.neighbor_index <= ok6_ff ? IDX_W'(part6_ff + FIN_W'(pz6_ff)) : '0;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe)
      else $error("accepted item gave no result at the expected latency");

   a_latency_back : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result strobe without a matching accepted item");

   a_valid_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.neighbor_valid |->
         $past(req_payload.direction, LAT) < DIR_COUNT)
      else $error("valid neighbor reported for an invalid direction");

endmodule

`default_nettype wire

// ----- tb/sv/hex_prism_grid_neighbor_index_unit_test.sv -----
`default_nettype none

module hex_prism_grid_neighbor_index_unit_test;
   import hpg_pkg::*;

   localparam int MAX_DIM = MAX_DIM_DEFAULT;
   localparam int LATENCY = 2 * $clog2(MAX_DIM) + 7;

   typedef struct packed {
      logic [IDX_W-1:0] cell_idx;
      logic [DIR_W-1:0] dir;
      logic             typed;
      logic [IDX_W-1:0] nidx;
      logic             nvalid;
   } probe_type;

   // Directed probes against the reset grid of 16 x 16 x 16 cells.
   localparam probe_type PROBES [24] = '{
      '{24'd0,        DIR_E,     1'b1, 24'd1,    1'b1},
      '{24'd0,        DIR_W_,    1'b1, 24'd0,    1'b0},
      '{24'd0,        DIR_NW,    1'b1, 24'd0,    1'b0},
      '{24'd0,        DIR_SE,    1'b1, 24'd16,   1'b1},
      '{24'd0,        DIR_SW,    1'b1, 24'd0,    1'b0},
      '{24'd0,        DIR_UP,    1'b1, 24'd256,  1'b1},
      '{24'd0,        DIR_DOWN,  1'b1, 24'd0,    1'b0},
      '{24'd4095,     DIR_E,     1'b1, 24'd0,    1'b0},
      '{24'd4095,     DIR_UP,    1'b1, 24'd0,    1'b0},
      '{24'd4095,     DIR_DOWN,  1'b1, 24'd3839, 1'b1},
      '{24'd4095,     DIR_NW,    1'b1, 24'd4079, 1'b1},
      '{24'd4095,     DIR_SE,    1'b1, 24'd0,    1'b0},
      '{24'd4096,     DIR_E,     1'b1, 24'd0,    1'b0},
      '{24'hFFFFFF,   DIR_NE,    1'b1, 24'd0,    1'b0},
      '{24'd0,        DIR_COUNT, 1'b1, 24'd0,    1'b0},
      '{24'd17,       4'hF,      1'b1, 24'd0,    1'b0},
      '{24'd16,       DIR_SW,    1'b1, 24'd32,   1'b1},
      '{24'd16,       DIR_NE,    1'b1, 24'd1,    1'b1},
      '{24'd16,       DIR_SE,    1'b1, 24'd33,   1'b1},
      '{24'd31,       DIR_E,     1'b1, 24'd0,    1'b0},
      '{24'd31,       DIR_NE,    1'b1, 24'd0,    1'b0},
      '{24'd31,       DIR_NW,    1'b1, 24'd15,   1'b1},
      '{24'd1000,     DIR_NE,    1'b0, 24'd0,    1'b0},
      '{24'd2345,     DIR_SW,    1'b0, 24'd0,    1'b0}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   logic    csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [CSR_DATA_W-1:0] grid_x;
   logic [CSR_DATA_W-1:0] grid_y;
   logic [CSR_DATA_W-1:0] grid_z;

   rsp_type pending_neighbors [$];
   int      error_count = 0;

   hex_prism_grid_neighbor_index_unit #(
      .MAX_DIM(MAX_DIM)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint grid_dim(logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return longint'(v);
   endfunction

   function automatic rsp_type lookup_neighbor(req_type q);
      longint  sx, sy, sz, area, idx, rem;
      longint  x, y, z, nx, ny, nz, dq, dr;
      rsp_type r;
      sx = grid_dim(grid_x);
      sy = grid_dim(grid_y);
      sz = grid_dim(grid_z);
      area = sx * sy;
      idx = longint'(q.cell_index);
      r = '0;
      if (idx >= area * sz || q.direction >= DIR_COUNT) return r;
      z = idx / area;
      rem = idx % area;
      y = rem / sx;
      x = rem % sx;
      nx = x;
      ny = y;
      nz = z;
      dq = 0;
      dr = 0;
      case (q.direction)
         DIR_UP:   nz = z + 1;
         DIR_DOWN: nz = z - 1;
         default: begin
            case (q.direction)
               DIR_E:  begin dq = 1;  dr = 0;  end
               DIR_SE: begin dq = 0;  dr = 1;  end
               DIR_SW: begin dq = -1; dr = 1;  end
               DIR_W_: begin dq = -1; dr = 0;  end
               DIR_NW: begin dq = 0;  dr = -1; end
               default: begin dq = 1; dr = -1; end
            endcase
            // Odd rows sit half a cell to the right, so the column shifts
            // by the change in floor(row / 2) on top of the cube step.
            ny = y + dr;
            nx = x - (y >>> 1) + dq + (ny >>> 1);
         end
      endcase
      if (nx < 0 || nx >= sx || ny < 0 || ny >= sy || nz < 0 || nz >= sz) return r;
      r.neighbor_index = IDX_W'(nx + ny * sx + nz * area);
      r.neighbor_valid = 1'b1;
      return r;
   endfunction

   function automatic longint pick_coord(longint n);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return n - 1;
         default: return longint'($urandom_range(0, int'(n - 1)));
      endcase
   endfunction

   function automatic req_type random_query();
      longint  sx, sy, sz;
      req_type q;
      sx = grid_dim(grid_x);
      sy = grid_dim(grid_y);
      sz = grid_dim(grid_z);
      if ($urandom_range(0, 7) == 0) begin
         q.cell_index = IDX_W'($urandom);
      end else begin
         q.cell_index = IDX_W'(pick_coord(sx) + pick_coord(sy) * sx
                               + pick_coord(sz) * sx * sy);
      end
      if ($urandom_range(0, 7) == 0) begin
         q.direction = DIR_W'($urandom_range(8, 15));
      end else begin
         q.direction = DIR_W'($urandom_range(0, 7));
      end
      return q;
   endfunction

   task automatic issue_query(req_type q, bit typed, rsp_type want);
      start = 1'b1;
      req_payload = q;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_neighbors.push_back(typed ? want : lookup_neighbor(q));
      @(negedge clock);
   endtask

   task automatic idle_gap(int mode);
      int pick, gap;
      pick = $urandom_range(0, 9);
      gap = 0;
      if (mode != 0) begin
         if (pick >= 9) gap = $urandom_range(5, 40);
         else if (pick >= 6) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_size(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      case (idx)
         CSR_SIZE_X: grid_x = v;
         CSR_SIZE_Y: grid_y = v;
         default:    grid_z = v;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] sx, logic [CSR_DATA_W-1:0] sy,
                            logic [CSR_DATA_W-1:0] sz, int n);
      int mode;
      start = 1'b0;
      while (pending_neighbors.size() != 0) @(negedge clock);
      write_size(CSR_SIZE_X, sx);
      write_size(CSR_SIZE_Y, sy);
      write_size(CSR_SIZE_Z, sz);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         issue_query(random_query(), 1'b0, '0);
         idle_gap(mode);
      end
      start = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_neighbors.size() == 0) begin
            $error("unexpected result item: neighbor_index %0d, neighbor_valid %0b",
                   rsp_payload.neighbor_index, rsp_payload.neighbor_valid);
            error_count++;
         end else begin
            want = pending_neighbors.pop_front();
            if (rsp_payload.neighbor_index !== want.neighbor_index) begin
               $error("neighbor_index: expected %0d, actual %0d",
                      want.neighbor_index, rsp_payload.neighbor_index);
               error_count++;
            end
            if (rsp_payload.neighbor_valid !== want.neighbor_valid) begin
               $error("neighbor_valid: expected %0b, actual %0b",
                      want.neighbor_valid, rsp_payload.neighbor_valid);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CSR_SIZE_X;
      csr_wdata = '0;
      grid_x = CSR_DATA_W'(SIZE_RESET);
      grid_y = CSR_DATA_W'(SIZE_RESET);
      grid_z = CSR_DATA_W'(SIZE_RESET);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 24; i++) begin
         issue_query('{cell_index: PROBES[i].cell_idx, direction: PROBES[i].dir},
                     PROBES[i].typed,
                     '{neighbor_index: PROBES[i].nidx, neighbor_valid: PROBES[i].nvalid});
         idle_gap(1);
      end

      run_phase(9'd1, 9'd1, 9'd1, 30);
      run_phase(9'd0, 9'd0, 9'd0, 30);
      run_phase(9'd256, 9'd256, 9'd256, 60);
      run_phase(9'd511, 9'd300, 9'd257, 40);
      run_phase(9'd5, 9'd3, 9'd4, 50);
      run_phase(9'd2, 9'd255, 9'd1, 40);
      for (int p = 0; p < 3; p++) begin
         run_phase(CSR_DATA_W'($urandom_range(0, 20)), CSR_DATA_W'($urandom_range(0, 20)),
                   CSR_DATA_W'($urandom_range(0, 511)), 50);
      end

      while (pending_neighbors.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("hex_prism_grid_neighbor_index_unit_test: clean");
      end else begin
         $display("hex_prism_grid_neighbor_index_unit_test: errors");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("hex_prism_grid_neighbor_index_unit_test: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/hpg_pkg.sv
sv/hpg_div_pipe.sv
sv/hex_prism_grid_neighbor_index_unit.sv
tb/sv/hex_prism_grid_neighbor_index_unit_test.sv
